FILE: rtl/kmsd_pkg.sv
// Shared constants and types for the key matrix scan debouncer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package kmsd_pkg;

  // Parameter defaults
  localparam int ROWS_DEF  = 8;
  localparam int COLS_DEF  = 16;
  localparam int DEPTH_DEF = 4;

  // Fixed field widths
  localparam int LEVEL_W   = 16;
  localparam int ROW_OUT_W = 3;
  localparam int RIU_W     = 4;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] LEVEL_INVERT = 32'hffffffff;
  localparam logic [RIU_W-1:0] RIU_RESET = RIU_W'(8);

  // Register indexes (byte address = 4 * index)
  typedef enum logic {
    REG_ACTIVE_LOW  = 1'b0,
    REG_ROWS_IN_USE = 1'b1
  } kmsd_reg_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } kmsd_qstat_t;

endpackage

`default_nettype wire

FILE: rtl/kmsd_front.sv
// Front end: config registers, row/head sequencing, sample conditioning.
// Depends on kmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmsd_front #(
  parameter int ROWS  = 8,
  parameter int COLS  = 16,
  parameter int DEPTH = 4,
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kmsd_pkg::APB_AW-1:0]   paddr,
  input  wire logic [kmsd_pkg::APB_DW-1:0]   pwdata,
  output logic      [kmsd_pkg::APB_DW-1:0]   prdata,
  input  wire logic                          item_valid,
  input  wire logic [kmsd_pkg::LEVEL_W-1:0]  column_levels,
  input  wire kmsd_pkg::kmsd_qstat_t         qstat,
  output logic                               push,
  output logic      [ROW_W-1:0]              push_row,
  output logic      [HEAD_W-1:0]             push_head,
  output logic      [kmsd_pkg::LEVEL_W-1:0]  push_sample,
  output logic                               push_last
);
  import kmsd_pkg::*;

  localparam logic [LEVEL_W-1:0] COL_MASK =
    (COLS >= LEVEL_W) ? {LEVEL_W{1'b1}} : LEVEL_W'((1 << COLS) - 1);
  localparam int CMP_W = 6;

  logic              active_low;
  logic [RIU_W-1:0]  rows_in_use;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  cur_row_next;
  logic [HEAD_W-1:0] head;
  logic [HEAD_W-1:0] head_next;
  logic [CMP_W-1:0]  limit;
  logic [ROW_W-1:0]  row;
  logic              cfg_wr;
  kmsd_reg_t         reg_sel;

  assign reg_sel = kmsd_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low  <= 1'b0;
      rows_in_use <= RIU_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ACTIVE_LOW:  active_low  <= pwdata[0];
        REG_ROWS_IN_USE: rows_in_use <= pwdata[RIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ACTIVE_LOW:  prdata = APB_DW'(active_low);
      REG_ROWS_IN_USE: prdata = APB_DW'(rows_in_use);
      default:         prdata = '0;
    endcase
  end

  // Effective row count: zero acts as one, clamp at ROWS
  always_comb begin
    if (rows_in_use == '0) begin
      limit = CMP_W'(1);
    end else if (CMP_W'(rows_in_use) > CMP_W'(ROWS)) begin
      limit = CMP_W'(ROWS);
    end else begin
      limit = CMP_W'(rows_in_use);
    end
  end

  assign row = (CMP_W'(cur_row) >= CMP_W'(ROWS)) ? ROW_W'(ROWS - 1) : cur_row;

  assign push        = item_valid && !qstat.full;
  assign push_row    = row;
  assign push_head   = head;
  assign push_last   = (CMP_W'(row) + CMP_W'(1)) >= limit;
  assign push_sample = (column_levels ^ (active_low ? LEVEL_INVERT[LEVEL_W-1:0] : '0))
                       & COL_MASK;

  always_comb begin
    cur_row_next = cur_row;
    head_next    = head;
    if (push) begin
      if (push_last) begin
        cur_row_next = '0;
        head_next    = (head == HEAD_W'(DEPTH - 1)) ? '0 : head + HEAD_W'(1);
      end else begin
        cur_row_next = row + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      head    <= '0;
    end else begin
      cur_row <= cur_row_next;
      head    <= head_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kmsd_queue.sv
// Small FIFO decoupling the front end from the history back end.
// Depends on kmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmsd_queue #(
  parameter int WIDTH = 8,
  parameter int QD    = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              pop,
  output logic      [WIDTH-1:0]  rdata,
  output kmsd_pkg::kmsd_qstat_t  qstat
);
  import kmsd_pkg::*;

  localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNT_W = $clog2(QD + 1);

  logic [WIDTH-1:0] mem [QD];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(QD));
  assign qstat.empty = (count == '0);
  assign rdata       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QD - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QD - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kmsd_back.sv
// Back end: per-row history ring update, OR merge and result register.
// Depends on kmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmsd_back #(
  parameter int ROWS  = 8,
  parameter int DEPTH = 4,
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire kmsd_pkg::kmsd_qstat_t          qstat,
  input  wire logic [ROW_W-1:0]               q_row,
  input  wire logic [HEAD_W-1:0]              q_head,
  input  wire logic [kmsd_pkg::LEVEL_W-1:0]   q_sample,
  input  wire logic                           q_last,
  output logic                                pop,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic      [kmsd_pkg::ROW_OUT_W-1:0] row_index,
  output logic      [kmsd_pkg::LEVEL_W-1:0]   pressed_columns,
  output logic                                scan_done
);
  import kmsd_pkg::*;

  logic [DEPTH-1:0][LEVEL_W-1:0] hist [ROWS];
  logic [DEPTH-1:0][LEVEL_W-1:0] ring;
  logic [LEVEL_W-1:0]            merged;

  assign pop  = !qstat.empty && (!result_valid || !result_stall);
  assign ring = hist[q_row];

  // New sample replaces the head slot; OR across the whole ring
  always_comb begin
    merged = q_sample;
    for (int d = 0; d < DEPTH; d++) begin
      if (HEAD_W'(d) != q_head) begin
        merged = merged | ring[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        hist[r] <= '0;
      end
    end else if (pop) begin
      hist[q_row][q_head] <= q_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_index       <= ROW_OUT_W'(q_row);
      pressed_columns <= merged;
      scan_done       <= q_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/key_matrix_scan_debounce.sv
// Key matrix scan debouncer, top level.
// Depends on kmsd_pkg, kmsd_front, kmsd_queue, kmsd_back.
//
// Usage:
//  - Item channel (item_valid / item_stall / column_levels): one transaction
//    per scanned row, carrying the raw column levels of the row being driven.
//    Rows are taken in order 0, 1, ... up to the effective row count.
//  - Result channel (result_valid / result_stall / row_index,
//    pressed_columns, scan_done): one transaction per item, in order.
//    pressed_columns is the OR of the row's last DEPTH samples, so presses
//    show at once and releases after DEPTH clean scans.
//  - APB port: reg 0 (addr 0) active_low_columns, reg 1 (addr 4)
//    rows_in_use. pready is tied high. Write only while idle.
//  - Path: an accepted item is written into the queue and, once the result
//    register is free, popped into it; result_valid rises with that pop.
//  - Throughput: one item per cycle while result_stall is low; the history
//    ring read-modify-write is a flop access in the back end.
//  - A 2-entry queue between front and back; item_stall rises when it is
//    full, i.e. after two items back up behind a stalled result.
//  - Reset (sync, active high): history cleared, row and head pointers at
//    zero, active_low_columns = 0, rows_in_use = 8.
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_scan_debounce #(
  parameter int ROWS  = kmsd_pkg::ROWS_DEF,
  parameter int COLS  = kmsd_pkg::COLS_DEF,
  parameter int DEPTH = kmsd_pkg::DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // APB config
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [kmsd_pkg::APB_AW-1:0]    paddr,
  input  wire logic [kmsd_pkg::APB_DW-1:0]    pwdata,
  output logic      [kmsd_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  // Item channel
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic [kmsd_pkg::LEVEL_W-1:0]   column_levels,
  // Result channel
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic      [kmsd_pkg::ROW_OUT_W-1:0] row_index,
  output logic      [kmsd_pkg::LEVEL_W-1:0]   pressed_columns,
  output logic                                scan_done
);
  import kmsd_pkg::*;

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENT_W  = 1 + HEAD_W + ROW_W + LEVEL_W;

  // Front-to-queue transaction
  logic              push;
  logic [ROW_W-1:0]  push_row;
  logic [HEAD_W-1:0] push_head;
  logic [LEVEL_W-1:0] push_sample;
  logic              push_last;

  // Queue-to-back transaction
  logic [ENT_W-1:0]  q_rdata;
  logic              pop;
  kmsd_qstat_t       qstat;

  assign pready     = 1'b1;
  assign item_stall = qstat.full;

  kmsd_front #(
    .ROWS  (ROWS),
    .COLS  (COLS),
    .DEPTH (DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .item_valid    (item_valid),
    .column_levels (column_levels),
    .qstat         (qstat),
    .push          (push),
    .push_row      (push_row),
    .push_head     (push_head),
    .push_sample   (push_sample),
    .push_last     (push_last)
  );

  kmsd_queue #(
    .WIDTH (ENT_W),
    .QD    (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_last, push_head, push_row, push_sample}),
    .pop   (pop),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  kmsd_back #(
    .ROWS  (ROWS),
    .DEPTH (DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .qstat           (qstat),
    .q_row           (q_rdata[LEVEL_W +: ROW_W]),
    .q_head          (q_rdata[LEVEL_W + ROW_W +: HEAD_W]),
    .q_sample        (q_rdata[LEVEL_W-1:0]),
    .q_last          (q_rdata[ENT_W-1]),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .row_index       (row_index),
    .pressed_columns (pressed_columns),
    .scan_done       (scan_done)
  );

`ifndef NO_ASSERTIONS
  // Back end must hold while the result register is stalled
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !pop)
    else $error("back end popped while result stalled");

  // An item into an idle pipe reaches the result port through the queue and the result register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && qstat.empty && !result_valid) |=> ##1 result_valid)
    else $error("idle-pipe item did not appear after two cycles");

  // Front never pushes into a full queue, back never pops an empty one
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full) && !(pop && qstat.empty))
    else $error("queue overflow or underflow");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/key_matrix_scan_debounce_test.sv
// Testbench for the key matrix scan debouncer: a self-checking bench with its own
// row-history model, APB register writes, random idles and a long result hold-off.
// Depends on kmsd_pkg and key_matrix_scan_debounce.
`timescale 1ns / 1ps

module key_matrix_scan_debounce_test;
  import kmsd_pkg::*;

  localparam int NUM_ROWS   = ROWS_DEF;
  localparam int HIST_DEPTH = DEPTH_DEF;
  localparam int HOLD_LEN   = 400;    // cycles of the long result hold-off
  localparam int DRAIN_MAX  = 5000;   // bound on waiting for results to come back

  // One debounced row report, as the block presents it.
  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [LEVEL_W-1:0]   pressed;
    logic                 scan_done;
  } scan_result_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  // DUT inputs, all known from time zero
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic                item_valid = 1'b0;
  logic [LEVEL_W-1:0]  column_levels = '0;
  logic                result_stall = 1'b0;

  // DUT outputs
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 item_stall;
  logic                 result_valid;
  logic [ROW_OUT_W-1:0] row_index;
  logic [LEVEL_W-1:0]   pressed_columns;
  logic                 scan_done;

  key_matrix_scan_debounce u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .column_levels  (column_levels),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .row_index      (row_index),
    .pressed_columns(pressed_columns),
    .scan_done      (scan_done)
  );

  // ---------------------------------------------------------------------------
  // Debounce model state: per-row sample ring, ring head, next row to scan,
  // and the two registers as the block should hold them.
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] key_history [NUM_ROWS][HIST_DEPTH];
  logic [1:0]         hist_head;
  logic [2:0]         scan_row;
  logic               cfg_active_low;
  logic [RIU_W-1:0]   cfg_rows;

  // Stimulus-side notion of which keys are held down on each row.
  logic [LEVEL_W-1:0] held_keys [NUM_ROWS];

  scan_result_t expected_scans[$];

  int err_cnt      = 0;
  int rows_sent    = 0;
  int scans_seen   = 0;
  int reg_writes   = 0;
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;

  // Hold-off requests: the test bumps hold_reqs, the stall process counts cycles.
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Advance the debouncer model by one scanned row and return its report.
  function automatic scan_result_t debounce_row(input logic [LEVEL_W-1:0] levels);
    scan_result_t res;
    logic [LEVEL_W-1:0] smp;
    int lim;
    int d;
    // zero rows acts as one, more than the matrix has acts as all of them
    lim = (cfg_rows == '0) ? 1 : (int'(cfg_rows) > NUM_ROWS) ? NUM_ROWS : int'(cfg_rows);
    smp = cfg_active_low ? ~levels : levels;
    key_history[scan_row][hist_head] = smp;
    res.row = scan_row;
    res.pressed = '0;
    for (d = 0; d < HIST_DEPTH; d++)
      res.pressed |= key_history[scan_row][d];
    // a row at or past the limit (rows_in_use lowered mid-scan) closes the scan
    res.scan_done = (int'(scan_row) + 1 >= lim);
    if (res.scan_done) begin
      scan_row = '0;
      hist_head = hist_head + 2'd1;
    end else begin
      scan_row = scan_row + 3'd1;
    end
    return res;
  endfunction

  // Mostly held keys with contact bounce, some all-released rows, some noise.
  function automatic logic [LEVEL_W-1:0] next_levels();
    logic [LEVEL_W-1:0] keys;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      keys = LEVEL_W'($urandom);
    end else if (pick < 20) begin
      keys = '0;
    end else begin
      if ($urandom_range(49) == 0)
        held_keys[scan_row] = '0;
      else if ($urandom_range(5) == 0)
        held_keys[scan_row][$urandom_range(LEVEL_W-1)] ^= 1'b1;
      keys = held_keys[scan_row];
      if ($urandom_range(3) == 0)
        keys[$urandom_range(LEVEL_W-1)] ^= 1'b1;
    end
    return cfg_active_low ? ~keys : keys;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern, hold-off counting, and the checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Each accepted result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    scan_result_t exp_scan;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (expected_scans.size() == 0) begin
        $display("%0t: result with nothing expected: row %0d pressed %h done %b",
                 $time, row_index, pressed_columns, scan_done);
        err_cnt++;
      end else begin
        exp_scan = expected_scans.pop_front();
        scans_seen++;
        if (row_index !== exp_scan.row) begin
          $display("%0t: row_index mismatch, expected %0d, got %0d",
                   $time, exp_scan.row, row_index);
          err_cnt++;
        end
        if (pressed_columns !== exp_scan.pressed) begin
          $display("%0t: pressed_columns mismatch (row %0d), expected %h, got %h",
                   $time, exp_scan.row, exp_scan.pressed, pressed_columns);
          err_cnt++;
        end
        if (scan_done !== exp_scan.scan_done) begin
          $display("%0t: scan_done mismatch (row %0d), expected %b, got %b",
                   $time, exp_scan.row, exp_scan.scan_done, scan_done);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks. All are entered and left right after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one row transaction, with random sender gaps ahead of it. item_valid
  // stays high on return so back-to-back rows need no extra NBA on it.
  task automatic send_row(input logic [LEVEL_W-1:0] levels);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    column_levels <= levels;
    do @(posedge clk); while (item_stall !== 1'b0);
    expected_scans.push_back(debounce_row(levels));
    rows_sent++;
  endtask

  // Sender pause: drop valid and wait until every expected result is back.
  task automatic wait_for_results();
    int waited;
    item_valid <= 1'b0;
    waited = 0;
    while (expected_scans.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (expected_scans.size() != 0) begin
      $display("%0t: %0d expected results never arrived, next row %0d",
               $time, expected_scans.size(), expected_scans[0].row);
      err_cnt += expected_scans.size();
      expected_scans.delete();
    end
    // let the pipe settle before touching registers
    repeat (4) @(posedge clk);
  endtask

  task automatic check_register(input kmsd_reg_t which, input logic [APB_DW-1:0] exp_val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'(4 * int'(which));
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== exp_val) begin
      $display("%0t: register %s readback mismatch, expected %h, got %h",
               $time, which.name(), exp_val, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register (only while idle), mirror it in the model, read it back.
  task automatic set_register(input kmsd_reg_t which, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(which));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    if (which == REG_ACTIVE_LOW)
      cfg_active_low = value[0];
    else
      cfg_rows = value[RIU_W-1:0];
    @(posedge clk);
    if (which == REG_ACTIVE_LOW)
      check_register(which, APB_DW'(cfg_active_low));
    else
      check_register(which, APB_DW'(cfg_rows));
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_registers();
    check_register(REG_ACTIVE_LOW, '0);
    @(posedge clk);
    check_register(REG_ROWS_IN_USE, APB_DW'(RIU_RESET));
    @(posedge clk);
  endtask

  // One full 8-row scan with field extremes and alternating patterns.
  task automatic test_field_extremes();
    send_row(16'h0000);
    send_row(16'hffff);
    send_row(16'haaaa);
    send_row(16'h5555);
    send_row(16'h0001);
    send_row(16'h8000);
    send_row(16'h0000);
    send_row(16'h0000);
    wait_for_results();
  endtask

  // Single-row scans: press shows at once, release only after DEPTH clean
  // samples; then the same with inverted (active low) columns.
  task automatic test_release_after_depth();
    set_register(REG_ROWS_IN_USE, 32'd1);
    send_row(16'hffff);
    repeat (HIST_DEPTH + 1) send_row(16'h0000);
    wait_for_results();
    // upper bits of the write data must be dropped
    set_register(REG_ACTIVE_LOW, 32'hffff_fffe | 32'd1);
    send_row(16'h0000);
    repeat (HIST_DEPTH) send_row(16'hffff);
    wait_for_results();
    set_register(REG_ACTIVE_LOW, 32'd0);
  endtask

  // Row count of zero, row count above the matrix, and lowering the row count
  // while the row pointer sits past the new limit.
  task automatic test_row_count_limits();
    set_register(REG_ROWS_IN_USE, 32'd0);
    send_row(16'h1234);
    send_row(16'h0f0f);
    wait_for_results();
    set_register(REG_ROWS_IN_USE, 32'hffff_fff0 | 32'd15);
    repeat (3) send_row(LEVEL_W'($urandom));
    wait_for_results();
    // row pointer is now 3, beyond a limit of 2
    set_register(REG_ROWS_IN_USE, 32'd2);
    send_row(16'hc003);
    send_row(16'h3ffc);
    wait_for_results();
  endtask

  // Result side held off for a long stretch while rows keep coming, so the
  // internal queue fills and item_stall has to push back.
  task automatic test_result_holdoff();
    set_register(REG_ROWS_IN_USE, 32'd8);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_reqs++;
    repeat (40) send_row(next_levels());
    wait_for_results();
  endtask

  // Random rows under one register setting and one idle/stall mix, with an
  // occasional full pause for all results to come back.
  task automatic test_random_scans(input int snd_pct, input int rcv_pct,
                                   input logic act_low, input logic [RIU_W-1:0] rows,
                                   input int count);
    int n;
    wait_for_results();
    set_register(REG_ACTIVE_LOW, APB_DW'(act_low));
    set_register(REG_ROWS_IN_USE, APB_DW'(rows));
    sender_idle_pct    = snd_pct;
    receiver_stall_pct = rcv_pct;
    for (n = 0; n < count; n++) begin
      send_row(next_levels());
      if (n % 40 == 39)
        wait_for_results();
    end
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    int d;
    for (r = 0; r < NUM_ROWS; r++) begin
      held_keys[r] = '0;
      for (d = 0; d < HIST_DEPTH; d++)
        key_history[r][d] = '0;
    end
    hist_head      = '0;
    scan_row       = '0;
    cfg_active_low = 1'b0;
    cfg_rows       = RIU_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_registers();
    test_field_extremes();
    test_release_after_depth();
    test_row_count_limits();
    test_result_holdoff();
    // idle mixes: none, sender-heavy, receiver-heavy, both light, then a
    // random setting whose row count may be zero or out of range
    test_random_scans(0,  0,  1'b0, 4'd8,  100);
    test_random_scans(73, 0,  1'b1, 4'd1,  100);
    test_random_scans(0,  73, 1'b0, 4'd15, 100);
    test_random_scans(15, 15, 1'b1, 4'd3,  100);
    test_random_scans(15, 15, 1'($urandom_range(1)), RIU_W'($urandom_range(15)), 100);

    receiver_stall_pct = 0;
    wait_for_results();
    repeat (10) @(posedge clk);

    $display("Covered %0d row transactions and %0d checked results across %0d register writes,",
             rows_sent, scans_seen, reg_writes);
    $display("with row-count limits, active-low columns, idle/stall mixes and a long hold-off.");
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
